// ===== src/hpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared types and constants of the head pointer motion mapper.
// ----------------------------------------------------------------------------
package hpm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_POINTER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE_Y   = 3'd4;

  localparam logic [15:0] GAIN_RESET     = 16'd32768;
  localparam logic [30:0] DEADZONE_RESET = 31'd327680;

  // Input kind and result event codes
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_RESET = 1'b1;
  localparam logic EV_MOVE    = 1'b0;
  localparam logic EV_KEY     = 1'b1;
  localparam logic MODE_MOUSE = 1'b0;
  localparam logic MODE_KEYS  = 1'b1;

  localparam int unsigned DELTA_W  = 32;  // scaled motion, 16 fractional bits
  localparam int unsigned RES_W    = 40;  // residue width
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = 2;
  localparam int unsigned QCNT_W   = 3;

  typedef struct packed {
    logic                      kind;
    logic signed [DELTA_W-1:0] mdx;
    logic signed [DELTA_W-1:0] mdy;
  } hpm_item_t;

  typedef struct packed {
    logic        mode;
    logic [30:0] dz_x;
    logic [30:0] dz_y;
  } hpm_cfg_t;

  typedef struct packed {
    logic        event_kind;
    logic [15:0] move_x;
    logic [15:0] move_y;
    logic [1:0]  key_dir;
    logic        key_pressed;
    logic        last;
  } hpm_result_t;

  typedef enum logic [1:0] {
    B_ACC,
    B_RND,
    B_SUB,
    B_EMIT
  } hpm_bstate_e;

endpackage

// ===== src/hpm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpm_front
// Accepts requests, applies the axis gains and hands scaled items to the queue.
// ----------------------------------------------------------------------------
module hpm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_kind_i,
  input  logic [23:0]       in_dx_i,
  input  logic [23:0]       in_dy_i,
  input  logic [15:0]       gain_x_i,
  input  logic [15:0]       gain_y_i,
  output logic              q_push_o,
  input  logic              q_ready_i,
  output hpm_pkg::hpm_item_t q_item_o
);
  import hpm_pkg::*;

  logic               f_valid_q;
  logic               f_kind_q;
  logic signed [39:0] prod_x_q, prod_y_q;
  logic signed [40:0] prod_x, prod_y;

  assign prod_x = $signed(in_dx_i) * $signed({1'b0, gain_x_i});
  assign prod_y = $signed(in_dy_i) * $signed({1'b0, gain_y_i});

  assign q_push_o   = f_valid_q && q_ready_i;
  assign in_ready_o = !f_valid_q || q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      f_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      f_kind_q <= in_kind_i;
      prod_x_q <= prod_x[39:0];
      prod_y_q <= prod_y[39:0];
    end
  end

  // Drop the 8 gain fraction bits, rounding toward minus infinity
  assign q_item_o.kind = f_kind_q;
  assign q_item_o.mdx  = prod_x_q[39:8];
  assign q_item_o.mdy  = prod_y_q[39:8];

endmodule

// ===== src/hpm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpm_queue
// Short queue of scaled items between the front and the back.
// ----------------------------------------------------------------------------
module hpm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hpm_pkg::hpm_item_t item_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               valid_o,
  output hpm_pkg::hpm_item_t item_o
);
  import hpm_pkg::*;

  hpm_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign ready_o = cnt_q != QCNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== src/hpm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpm_back
// Updates position and residue, rounds moves or finds key changes, and
// sends the results one a cycle while not stalled, via the output register.
// ----------------------------------------------------------------------------
module hpm_back #(
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hpm_pkg::hpm_cfg_t    cfg_i,
  input  logic                 q_valid_i,
  input  hpm_pkg::hpm_item_t   q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hpm_pkg::hpm_result_t out_o
);
  import hpm_pkg::*;

  localparam int unsigned P = POSITION_BITS;

  hpm_bstate_e           state_q, state_d;
  logic signed [P-1:0]   pos_x_q, pos_y_q;
  logic [RES_W-1:0]      res_x_q, res_y_q;
  logic [3:0]            held_q, hit_q, pend_q, pend_d;
  logic [15:0]           ix_q, iy_q;
  logic                  out_valid_q;
  hpm_result_t           out_q;

  logic [3:0]            sel_oh, rest;
  logic [1:0]            sel_idx;
  logic                  load;
  logic [P-1:0]          dzx_ext, dzy_ext;
  logic [3:0]            hit;

  function automatic logic [P-1:0] pos_add(input logic [P-1:0] p,
                                            input logic [DELTA_W-1:0] d);
    logic [P:0] s;
    s = {p[P-1], p} + {{(P+1-DELTA_W){d[DELTA_W-1]}}, d};
    if (s[P] != s[P-1]) begin
      pos_add = s[P] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}};
    end else begin
      pos_add = s[P-1:0];
    end
  endfunction

  function automatic logic [RES_W-1:0] res_add(input logic [RES_W-1:0] r,
                                                input logic [DELTA_W-1:0] d);
    logic [RES_W:0] s;
    s = {r[RES_W-1], r} + {{(RES_W+1-DELTA_W){d[DELTA_W-1]}}, d};
    if (s[RES_W] != s[RES_W-1]) begin
      res_add = s[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      res_add = s[RES_W-1:0];
    end
  endfunction

  // Round half away from zero to whole pixels, saturated to 16 bits
  function automatic logic [15:0] round_px(input logic [RES_W-1:0] r);
    logic [RES_W-1:0] mag;
    logic [RES_W:0]   sum;
    logic [24:0]      q;
    mag = r[RES_W-1] ? (~r + 1'b1) : r;
    sum = {1'b0, mag} + (RES_W+1)'(32768);
    q   = sum[RES_W:16];
    if (!r[RES_W-1]) begin
      round_px = (q > 25'd32767) ? 16'h7fff : q[15:0];
    end else begin
      round_px = (q > 25'd32768) ? 16'h8000 : (~q[15:0] + 1'b1);
    end
  endfunction

  assign dzx_ext = {{(P-31){1'b0}}, cfg_i.dz_x};
  assign dzy_ext = {{(P-31){1'b0}}, cfg_i.dz_y};

  always_comb begin
    hit = 4'b0000;
    if ($signed(pos_x_q) > $signed(dzx_ext)) begin
      hit[3] = 1'b1;
    end else if ($signed(pos_x_q) < -$signed(dzx_ext)) begin
      hit[2] = 1'b1;
    end
    if ($signed(pos_y_q) > $signed(dzy_ext)) begin
      hit[1] = 1'b1;
    end else if ($signed(pos_y_q) < -$signed(dzy_ext)) begin
      hit[0] = 1'b1;
    end
  end

  // Pick the lowest pending event: up, down, left, right
  always_comb begin
    priority if (pend_q[0]) begin
      sel_idx = 2'd0;
    end else if (pend_q[1]) begin
      sel_idx = 2'd1;
    end else if (pend_q[2]) begin
      sel_idx = 2'd2;
    end else begin
      sel_idx = 2'd3;
    end
  end

  assign sel_oh  = 4'b0001 << sel_idx;
  assign rest    = pend_q & ~sel_oh;
  assign load    = (state_q == B_EMIT) && (!out_valid_q || out_ready_i);
  assign q_pop_o = (state_q == B_ACC) && q_valid_i;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    unique case (state_q)
      B_ACC: begin
        if (q_valid_i && q_item_i.kind == KIND_TICK) begin
          state_d = B_RND;
        end
      end
      B_RND: begin
        state_d = B_SUB;
      end
      B_SUB: begin
        if (cfg_i.mode == MODE_MOUSE) begin
          pend_d = {3'b000, (ix_q != '0) || (iy_q != '0)};
        end else begin
          pend_d = held_q ^ hit_q;
        end
        state_d = (pend_d != '0) ? B_EMIT : B_ACC;
      end
      B_EMIT: begin
        if (load) begin
          pend_d = rest;
          if (rest == '0) begin
            state_d = B_ACC;
          end
        end
      end
      default: begin
        state_d = B_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_ACC;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      res_x_q <= '0;
      res_y_q <= '0;
      held_q  <= '0;
    end else begin
      if (q_pop_o) begin
        if (q_item_i.kind == KIND_RESET) begin
          pos_x_q <= '0;
          pos_y_q <= '0;
        end else begin
          pos_x_q <= pos_add(pos_x_q, q_item_i.mdx);
          pos_y_q <= pos_add(pos_y_q, q_item_i.mdy);
          if (cfg_i.mode == MODE_MOUSE) begin
            res_x_q <= res_add(res_x_q, q_item_i.mdx);
            res_y_q <= res_add(res_y_q, q_item_i.mdy);
          end
        end
      end
      if (state_q == B_SUB) begin
        if (cfg_i.mode == MODE_MOUSE) begin
          // Keep what could not be sent
          res_x_q <= res_x_q - {{8{ix_q[15]}}, ix_q, 16'h0000};
          res_y_q <= res_y_q - {{8{iy_q[15]}}, iy_q, 16'h0000};
        end else begin
          held_q <= hit_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_RND) begin
      ix_q  <= round_px(res_x_q);
      iy_q  <= round_px(res_y_q);
      hit_q <= hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.last <= (rest == '0);
      if (cfg_i.mode == MODE_MOUSE) begin
        out_q.event_kind  <= EV_MOVE;
        out_q.move_x      <= ix_q;
        out_q.move_y      <= iy_q;
        out_q.key_dir     <= 2'd0;
        out_q.key_pressed <= 1'b0;
      end else begin
        out_q.event_kind  <= EV_KEY;
        out_q.move_x      <= '0;
        out_q.move_y      <= '0;
        out_q.key_dir     <= sel_idx;
        out_q.key_pressed <= hit_q[sel_idx];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_move_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.event_kind == EV_MOVE |-> out_q.move_x != '0 || out_q.move_y != '0)
    else $error("zero move result sent");

  a_key_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.event_kind == EV_KEY |-> out_q.move_x == '0 && out_q.move_y == '0)
    else $error("key result carries motion");

  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != B_SUB |=> $stable(held_q))
    else $error("held keys changed outside update step");

  a_pend_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != B_EMIT |-> pend_q == '0)
    else $error("pending events outside emit state");

endmodule

// ===== src/head_pointer_motion_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// head_pointer_motion_mapper
// Maps scaled head motion to relative mouse moves or direction key events.
// ----------------------------------------------------------------------------
// The front takes a request in any cycle its one-item stage can move on,
// multiplies both deltas by their gains in that cycle and queues the scaled
// item (four entries). The back sequencer sets the pace: a report tick
// has its position and residue added, is rounded or compared with the
// deadzones, updates residue or keys and sends its results in turn; a
// position reset needs only the add. Results leave through a registered
// output stage, so the back works on while a result waits to be taken.
module head_pointer_motion_mapper #(
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [hpm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hpm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // raw_dx[23:0], raw_dy[47:24]
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // move_x[15:0], move_y[31:16], key_dir[33:32],
                                      // key_pressed[34], zero[39:35]
  output logic        m_axis_tuser,   // event_kind
  output logic        m_axis_tlast
);
  import hpm_pkg::*;

  logic        mode_q;
  logic [15:0] gain_x_q, gain_y_q;
  logic [30:0] dz_x_q, dz_y_q;
  hpm_cfg_t    cfg;

  logic        q_push, q_ready, q_pop, q_valid;
  hpm_item_t   f_item, q_item;
  hpm_result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_MOUSE;
      gain_x_q <= GAIN_RESET;
      gain_y_q <= GAIN_RESET;
      dz_x_q   <= DEADZONE_RESET;
      dz_y_q   <= DEADZONE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POINTER_MODE: mode_q   <= cfg_wdata_i[0];
        CFG_GAIN_X:       gain_x_q <= cfg_wdata_i[15:0];
        CFG_GAIN_Y:       gain_y_q <= cfg_wdata_i[15:0];
        CFG_DEADZONE_X:   dz_x_q   <= cfg_wdata_i;
        CFG_DEADZONE_Y:   dz_y_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg.mode = mode_q;
  assign cfg.dz_x = dz_x_q;
  assign cfg.dz_y = dz_y_q;

  hpm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_dx_i    (s_axis_tdata[23:0]),
    .in_dy_i    (s_axis_tdata[47:24]),
    .gain_x_i   (gain_x_q),
    .gain_y_i   (gain_y_q),
    .q_push_o   (q_push),
    .q_ready_i  (q_ready),
    .q_item_o   (f_item)
  );

  hpm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  hpm_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {5'b00000, res.key_pressed, res.key_dir, res.move_y, res.move_x};
  assign m_axis_tuser = res.event_kind;
  assign m_axis_tlast = res.last;

endmodule
